// ===== hw/rtl/wsfu_pkg.sv =====
// Package for the WebSocket frame unmasker: parse phases, result codes,
// header verdict struct and protocol constants. No dependencies.

package wsfu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN7,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_KEY,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_LEN64    = 2'd1,
    ST_BADLEN   = 2'd2,
    ST_UNMASKED = 2'd3
  } status_t;

  // 7-bit length escapes
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam int unsigned KEY_BYTES = 4;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_BYTES);
  localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(KEY_BYTES - 1);

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  // Header check result: ok, or the error status to report
  typedef struct packed {
    logic    ok;
    status_t status;
  } hdr_verdict_t;

endpackage

// ===== hw/rtl/wsfu_channels.sv =====
// Valid/ready channel interfaces of the WebSocket frame unmasker:
// raw frame bytes in, unmasked payload items out. No dependencies.

interface wsfu_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface wsfu_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic [1:0] status;

  modport source (output valid, payload_byte, last_byte, status, input ready);
  modport sink (input valid, payload_byte, last_byte, status, output ready);
endinterface

// ===== hw/rtl/wsfu_hdr_check.sv =====
// Frame header check: length range against the configured maximum and the
// mask bit. Depends on wsfu_pkg.

module wsfu_hdr_check import wsfu_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic [15:0]  length,
  input  logic         masked,
  input  logic [15:0]  max_length,
  output hdr_verdict_t verdict
);

  logic too_wide;
  logic bad_len;

  // shifting by 16 leaves zero, so the full-width case needs no special arm
  assign too_wide = (length >> LENGTH_BITS) != 16'd0;
  assign bad_len  = (length == 16'd0) || too_wide || (length >= max_length);

  always_comb begin
    if (bad_len) begin
      verdict = '{ok: 1'b0, status: ST_BADLEN};
    end else if (!masked) begin
      verdict = '{ok: 1'b0, status: ST_UNMASKED};
    end else begin
      verdict = '{ok: 1'b1, status: ST_DATA};
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_unmasker.sv =====
// WebSocket frame unmasker, top level. Depends on wsfu_pkg, the channel
// interfaces in wsfu_channels.sv and wsfu_hdr_check.
//
// Takes one raw frame byte per item on `frame` and gives unmasked payload
// bytes on `payload`. An item with frame_start set begins a new frame (and
// drops any frame in progress without a result); it is the flags byte and
// is skipped. The next byte carries the mask bit and the 7-bit length, 126
// selecting a big-endian 16-bit extended length. A 64-bit length (status
// 1), a zero length or one not below max_length or not fitting LENGTH_BITS
// bits (status 2), or an unmasked frame (status 3) gives a single error
// result with last_byte set and a zero byte, then the rest of the frame is
// ignored. After the 4 key bytes every payload byte is XORed with key byte
// (index mod 4); the final one has last_byte set. Bytes past the payload
// are dropped. Throughput is one item per clock while frame.ready is high:
// the parse state updates in the accepting cycle and the result lands in
// the output register, seen in the cycle after the accept. frame.ready is
// low only while that register holds a result that payload.ready does not
// take in the same cycle. The user must write max_length (reset 4096) via
// max_length_we/max_length_wdata only while the block is idle; unenforced.

module websocket_frame_unmasker import wsfu_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 max_length_we,
  input  logic [15:0]          max_length_wdata,
  wsfu_frame_if.sink           frame,
  wsfu_payload_if.source       payload
);

  // configuration
  logic [15:0] max_length;

  // parse state
  phase_t                 phase, phase_next;
  logic                   mask_present, mask_present_next;
  logic [LENGTH_BITS-1:0] payload_length, payload_length_next;
  logic [LENGTH_BITS-1:0] byte_counter, byte_counter_next;
  logic [7:0]             len_hi, len_hi_next;
  logic [7:0]             mask_key [KEY_BYTES];
  logic                   key_we;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  status_t    out_status;

  // result of this cycle
  logic       emit;
  logic [7:0] res_byte;
  logic       res_last;
  status_t    res_status;

  logic                   accept;
  logic [7:0]             din;
  logic [6:0]             len7;
  logic [15:0]            hdr_len;
  logic                   hdr_masked;
  hdr_verdict_t           verdict;
  logic [KEY_IDX_W-1:0]   key_idx;
  logic [LENGTH_BITS-1:0] cnt_plus;

  assign frame.ready = !out_valid || payload.ready;
  assign accept      = frame.valid && frame.ready;
  assign din         = frame.data_byte;
  assign len7        = din[6:0];
  assign key_idx     = byte_counter[KEY_IDX_W-1:0];
  assign cnt_plus    = byte_counter + LENGTH_BITS'(1);

  // header length: 7-bit form straight from the byte, else high byte + this
  always_comb begin
    if (phase == PH_LEN7) begin
      hdr_len    = {9'd0, len7};
      hdr_masked = din[7];
    end else begin
      hdr_len    = {len_hi, din};
      hdr_masked = mask_present;
    end
  end

  wsfu_hdr_check #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_hdr_check (
    .length     (hdr_len),
    .masked     (hdr_masked),
    .max_length (max_length),
    .verdict    (verdict)
  );

  always_comb begin
    phase_next          = phase;
    mask_present_next   = mask_present;
    payload_length_next = payload_length;
    byte_counter_next   = byte_counter;
    len_hi_next         = len_hi;
    key_we              = 1'b0;
    emit                = 1'b0;
    res_byte            = 8'd0;
    res_last            = 1'b1;
    res_status          = ST_DATA;

    if (accept) begin
      if (frame.frame_start) begin
        // flags byte of a new frame
        phase_next          = PH_LEN7;
        mask_present_next   = 1'b0;
        payload_length_next = '0;
        byte_counter_next   = '0;
      end else begin
        unique case (phase)
          PH_LEN7: begin
            mask_present_next = din[7];
            if (len7 == LEN7_EXT64) begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              res_status = ST_LEN64;
            end else if (len7 == LEN7_EXT16) begin
              phase_next = PH_EXT_HI;
            end else if (!verdict.ok) begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              res_status = verdict.status;
            end else begin
              payload_length_next = hdr_len[LENGTH_BITS-1:0];
              byte_counter_next   = '0;
              phase_next          = PH_KEY;
            end
          end
          PH_EXT_HI: begin
            len_hi_next = din;
            phase_next  = PH_EXT_LO;
          end
          PH_EXT_LO: begin
            if (!verdict.ok) begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              res_status = verdict.status;
            end else begin
              payload_length_next = hdr_len[LENGTH_BITS-1:0];
              byte_counter_next   = '0;
              phase_next          = PH_KEY;
            end
          end
          PH_KEY: begin
            key_we = 1'b1;
            if (key_idx == KEY_LAST) begin
              byte_counter_next = '0;
              phase_next        = PH_PAYLOAD;
            end else begin
              byte_counter_next = cnt_plus;
            end
          end
          PH_PAYLOAD: begin
            // counter never passes length - 1, so the increment cannot wrap
            emit              = 1'b1;
            res_byte          = din ^ mask_key[key_idx];
            res_last          = (cnt_plus == payload_length);
            res_status        = ST_DATA;
            byte_counter_next = cnt_plus;
            if (res_last) begin
              phase_next = PH_DONE;
            end
          end
          PH_IDLE, PH_DONE: begin
            // ignored until the next frame start
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (max_length_we) begin
      max_length <= max_length_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      mask_present   <= 1'b0;
      payload_length <= '0;
      byte_counter   <= '0;
    end else begin
      phase          <= phase_next;
      mask_present   <= mask_present_next;
      payload_length <= payload_length_next;
      byte_counter   <= byte_counter_next;
    end
  end

  // key bytes arrive first-to-last as index 0..3; len_hi is always written
  // before it is read
  always_ff @(posedge clk) begin
    len_hi <= len_hi_next;
    if (key_we) begin
      mask_key[key_idx] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (payload.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= res_byte;
      out_last   <= res_last;
      out_status <= res_status;
    end
  end

  assign payload.valid        = out_valid;
  assign payload.payload_byte = out_byte;
  assign payload.last_byte    = out_last;
  assign payload.status       = out_status;

endmodule

// ===== hw/rtl/wsfu_checker.sv =====
// Port-level checks for websocket_frame_unmasker, bound to the top level.
// Depends on wsfu_pkg and the top level's channel ports.

module wsfu_checker import wsfu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_start,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [1:0] out_status
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_last) && $stable(out_status))
    else $error("stalled result changed or dropped");

  // error results end the frame and carry a zero byte
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_DATA) |-> out_last && (out_byte == 8'd0))
    else $error("error result without last or with data");

  // a frame start never produces a result
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_start |=> !out_valid)
    else $error("result after a frame start item");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (frame.valid),
  .in_ready   (frame.ready),
  .in_start   (frame.frame_start),
  .out_valid  (payload.valid),
  .out_ready  (payload.ready),
  .out_byte   (payload.payload_byte),
  .out_last   (payload.last_byte),
  .out_status (payload.status)
);

// ===== tb/websocket_frame_unmasker_tb.sv =====
// Self-checking testbench for websocket_frame_unmasker: a queue-fed byte driver,
// a result monitor and a cycle-free predictor of the unmasking. Depends on
// wsfu_pkg, the channel interfaces in wsfu_channels.sv and the block itself.

module websocket_frame_unmasker_tb;
  import wsfu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned LEN_LIMIT = (1 << LEN_BITS) - 1;
  localparam int unsigned DRAIN_MAX = 20000;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    status_t    status;
  } payload_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // tb-side drive registers, all known from time zero
  logic        src_valid   = 1'b0;
  logic [7:0]  src_data    = 8'h00;
  logic        src_start   = 1'b0;
  logic        snk_ready   = 1'b0;
  logic        max_len_we  = 1'b0;
  logic [15:0] max_len_wd  = 16'h0000;

  wsfu_frame_if   frame_if ();
  wsfu_payload_if pay_if ();

  assign frame_if.valid       = src_valid;
  assign frame_if.data_byte   = src_data;
  assign frame_if.frame_start = src_start;
  assign pay_if.ready         = snk_ready;

  websocket_frame_unmasker #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .max_length_we    (max_len_we),
    .max_length_wdata (max_len_wd),
    .frame            (frame_if),
    .payload          (pay_if)
  );

  always #5 clk = ~clk;

  frame_item_t   pending_bytes[$];
  payload_item_t expected_payload[$];

  int idle_pct  = 0;
  int stall_pct = 0;

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_err_res  = 0;
  int n_frames   = 0;
  int n_settings = 0;
  int n_fail     = 0;

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the parse state of the block
  // ---------------------------------------------------------------------
  phase_t      ps_phase   = PH_IDLE;
  int unsigned ps_len     = 0;
  int unsigned ps_count   = 0;
  logic [31:0] ps_key     = '0;
  logic        ps_masked  = 1'b0;
  logic [15:0] ps_max_len = MAX_LENGTH_RESET;

  // Length then mask check once the header is complete.
  function automatic bit check_header(output payload_item_t r);
    r = '{8'h00, 1'b1, ST_DATA};
    if (ps_len == 0 || ps_len > LEN_LIMIT || ps_len >= ps_max_len) begin
      ps_phase = PH_DONE;
      r.status = ST_BADLEN;
      return 1'b1;
    end
    if (!ps_masked) begin
      ps_phase = PH_DONE;
      r.status = ST_UNMASKED;
      return 1'b1;
    end
    ps_count = 0;
    ps_key   = '0;
    ps_phase = PH_KEY;
    return 1'b0;
  endfunction

  // One accepted byte in, zero or one payload item out.
  function automatic bit unmask_step(input logic [7:0] b, input logic st,
                                     output payload_item_t r);
    logic [7:0] kb;
    logic       fin;
    r = '{8'h00, 1'b0, ST_DATA};
    if (st) begin
      // new frame, even in mid-frame; this byte is the flags byte
      ps_phase  = PH_LEN7;
      ps_len    = 0;
      ps_count  = 0;
      ps_key    = '0;
      ps_masked = 1'b0;
      return 1'b0;
    end
    case (ps_phase)
      PH_LEN7: begin
        ps_masked = b[7];
        if (b[6:0] == LEN7_EXT64) begin
          ps_phase = PH_DONE;
          r = '{8'h00, 1'b1, ST_LEN64};
          return 1'b1;
        end
        if (b[6:0] == LEN7_EXT16) begin
          ps_phase = PH_EXT_HI;
          return 1'b0;
        end
        ps_len = b[6:0];
        return check_header(r);
      end
      PH_EXT_HI: begin
        ps_len   = {b, 8'h00};
        ps_phase = PH_EXT_LO;
        return 1'b0;
      end
      PH_EXT_LO: begin
        ps_len = (ps_len | b) & 32'hFFFF;
        return check_header(r);
      end
      PH_KEY: begin
        ps_key   = {ps_key[23:0], b};
        ps_count = (ps_count + 1) & 32'hFFFF;
        if (ps_count == KEY_BYTES) begin
          ps_count = 0;
          ps_phase = PH_PAYLOAD;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        // first key byte sits in the top of ps_key
        kb       = 8'(ps_key >> (8 * (3 - (ps_count & 3))));
        ps_count = (ps_count + 1) & 32'hFFFF;
        fin      = (ps_count >= ps_len);
        if (fin) ps_phase = PH_DONE;
        r = '{b ^ kb, fin, ST_DATA};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued bytes, random gaps per idle_pct
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    frame_item_t it;
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || frame_if.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        it = pending_bytes.pop_front();
        src_valid <= 1'b1;
        src_data  <= it.data_byte;
        src_start <= it.frame_start;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Accept side: every byte taken by the block goes through the predictor.
  always @(posedge clk) begin : byte_accept
    payload_item_t r;
    if (!rst && frame_if.valid && frame_if.ready) begin
      n_accepted++;
      if (unmask_step(frame_if.data_byte, frame_if.frame_start, r)) begin
        expected_payload.push_back(r);
        n_results++;
        if (r.status != ST_DATA) n_err_res++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure and in-order field checks
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : payload_monitor
    payload_item_t want;
    if (rst) snk_ready <= 1'b0;
    else     snk_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && pay_if.valid && pay_if.ready) begin
      if (expected_payload.size() == 0) begin
        $error("unexpected item: payload_byte %02h last_byte %0b status %0d",
               pay_if.payload_byte, pay_if.last_byte, pay_if.status);
        n_fail++;
      end else begin
        want = expected_payload.pop_front();
        if (pay_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %02h, actual %02h",
                 want.payload_byte, pay_if.payload_byte);
          n_fail++;
        end
        if (pay_if.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte, pay_if.last_byte);
          n_fail++;
        end
        if (pay_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, pay_if.status);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic st);
    pending_bytes.push_back('{b, st});
    n_pushed++;
  endtask

  // Flags byte, mask/len7 byte, optional 16-bit length, then `follow` bytes
  // (key, payload, trailing junk; whatever the header makes of them).
  task automatic add_frame(input bit masked, input logic [6:0] len7,
                           input logic [15:0] ext_len, input int follow);
    push_item(8'($urandom), 1'b1);
    push_item({masked, len7}, 1'b0);
    if (len7 == LEN7_EXT16) begin
      push_item(ext_len[15:8], 1'b0);
      push_item(ext_len[7:0], 1'b0);
    end
    repeat (follow) push_item(8'($urandom), 1'b0);
    n_frames++;
  endtask

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL:      begin idle_pct = 0;  stall_pct = 0;  end
      PACE_SRC_IDLE:  begin idle_pct = 47; stall_pct = 0;  end
      PACE_SNK_STALL: begin idle_pct = 0;  stall_pct = 47; end
      default:        begin idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // Only called once the block is idle.
  task automatic write_max_len(input logic [15:0] v);
    @(posedge clk);
    max_len_we <= 1'b1;
    max_len_wd <= v;
    @(posedge clk);
    max_len_we <= 1'b0;
    ps_max_len = v;
    n_settings++;
  endtask

  // Wait for every byte to be taken and every result to come back, then
  // let the output register settle.
  task automatic drain();
    int unsigned n;
    n = 0;
    while (n_accepted != n_pushed) @(posedge clk);
    while (expected_payload.size() != 0 && n < DRAIN_MAX) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Random frames, mostly well formed, until n_items bytes are queued.
  task automatic random_frames(input int n_items);
    int goal;
    int k;
    int len;
    int ml;
    int tail;
    goal = n_pushed + n_items;
    ml   = ps_max_len;
    while (n_pushed < goal) begin
      k    = $urandom_range(0, 99);
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (k < 55) begin
        len = $urandom_range(1, 20);
        add_frame(1'b1, 7'(len), 16'h0, 4 + len + tail);
      end else if (k < 65) begin
        // extended form with a short length, zero included
        len = $urandom_range(0, 40);
        add_frame(1'b1, LEN7_EXT16, 16'(len), 4 + len + tail);
      end else if (k < 70) begin
        // huge extended lengths, frame cut short by the next start
        case ($urandom_range(0, 3))
          0:       len = ml - 1;
          1:       len = 65535;
          2:       len = 65534;
          default: len = $urandom_range(0, 65535);
        endcase
        add_frame(1'b1, LEN7_EXT16, 16'(len), $urandom_range(0, 10));
      end else if (k < 76) begin
        add_frame(1'($urandom), LEN7_EXT64, 16'h0, $urandom_range(0, 3));
      end else if (k < 84) begin
        len = $urandom_range(1, 20);
        add_frame(1'b0, 7'(len), 16'h0, $urandom_range(0, 4));
      end else if (k < 90) begin
        if ($urandom_range(0, 1) == 0)
          add_frame(1'($urandom), 7'd0, 16'h0, $urandom_range(0, 4));
        else
          add_frame(1'($urandom), LEN7_EXT16, 16'($urandom_range(ml, 65535)),
                    $urandom_range(0, 4));
      end else if (k < 95) begin
        len = $urandom_range(2, 20);
        add_frame(1'b1, 7'(len), 16'h0, $urandom_range(0, 3 + len));
      end else begin
        // loose bytes, start flag now and then
        repeat ($urandom_range(1, 6)) push_item(8'($urandom), $urandom_range(0, 5) == 0);
      end
    end
    // close with a zero-length header so the block ends the phase in done
    add_frame(1'b0, 7'd0, 16'h0, 0);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset max_length.
    set_pace(PACE_FULL);
    push_item(8'h00, 1'b0);                    // bytes before any frame start
    push_item(8'hFF, 1'b0);
    add_frame(1'b1, LEN7_EXT64, 16'h0, 0);     // 64-bit length
    add_frame(1'b0, 7'd5, 16'h0, 0);           // not masked
    add_frame(1'b0, 7'd0, 16'h0, 0);           // zero and unmasked: length wins
    add_frame(1'b1, LEN7_EXT16, MAX_LENGTH_RESET, 0);  // length equal to max
    add_frame(1'b1, 7'd2, 16'h0, 2);           // cut off mid-key by next start
    add_frame(1'b1, 7'd1, 16'h0, 5 + 1);       // one payload byte plus junk
    drain();

    write_max_len(16'hFFFF);
    set_pace(PACE_SRC_IDLE);
    random_frames(220);
    drain();

    write_max_len(16'd1);                      // every length too long
    set_pace(PACE_SNK_STALL);
    random_frames(200);
    drain();

    write_max_len(16'd0);                      // every length invalid
    set_pace(PACE_BOTH);
    random_frames(100);
    drain();

    // one full frame past 256 payload bytes
    write_max_len(16'd300);
    set_pace(PACE_FULL);
    add_frame(1'b1, LEN7_EXT16, 16'd299, 4 + 299);
    random_frames(220);
    drain();

    write_max_len(16'($urandom_range(2, 140)));
    set_pace(PACE_SRC_IDLE);
    random_frames(220);
    drain();

    write_max_len(MAX_LENGTH_RESET);
    set_pace(PACE_BOTH);
    random_frames(220);
    drain();

    write_max_len(16'hFFFF);
    set_pace(PACE_SNK_STALL);
    random_frames(220);
    drain();

    if (expected_payload.size() != 0) begin
      $error("%0d expected items never arrived", expected_payload.size());
      n_fail++;
    end

    $display("covered %0d input bytes in %0d frames over %0d max_length settings",
             n_accepted, n_frames, n_settings);
    $display("checked %0d output items, %0d of them error reports", n_results, n_err_res);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("run limit reached with %0d bytes still to accept", n_pushed - n_accepted);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wsfu_pkg.sv
hw/rtl/wsfu_channels.sv
hw/rtl/wsfu_hdr_check.sv
hw/rtl/websocket_frame_unmasker.sv
hw/rtl/wsfu_checker.sv
tb/websocket_frame_unmasker_tb.sv
